### design/pkhm_pkg.sv
// ----------------------------------------------------------------------------
// pkhm_pkg
// Shared constants, codes and types of the point key hash multimap.
// ----------------------------------------------------------------------------
package pkhm_pkg;

  // Table geometry (BUCKETS is a power of two: the bucket is the low hash bits)
  localparam int BUCKETS   = 1024;
  localparam int CAPACITY  = 1024;
  localparam int COORD_W   = 32;

  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int PTR_W     = $clog2(CAPACITY + 1);   // holds the null link too
  localparam int KEY_W     = 3 * COORD_W;
  localparam int VALUE_W   = 32;
  localparam int HASH_W    = 32;
  localparam int COUNT_W   = 11;                     // result field width

  localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

  // Hash multipliers, one per axis
  localparam int NUM_AXES  = 3;
  localparam int MUL_W     = 15;
  localparam logic [MUL_W-1:0] HASH_MUL [NUM_AXES] = '{15'd18397, 15'd20483, 15'd29303};

  // Operation codes
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_SEARCH = 2'd1;
  localparam logic [1:0] FN_DELETE = 2'd2;

  // Token passed along the hash cells
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] acc;
  } hash_tok_t;

endpackage

### design/pkhm_ram.sv
// ----------------------------------------------------------------------------
// pkhm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pkhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/pkhm_cell.sv
// ----------------------------------------------------------------------------
// pkhm_cell
// One hash cell: adds its coordinate times its multiplier to the running
// sum and hands the token to the next cell.
// ----------------------------------------------------------------------------
module pkhm_cell import pkhm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  hash_tok_t          tok_i,
  input  logic [COORD_W-1:0] coord_i,
  input  logic [MUL_W-1:0]   mul_i,
  output hash_tok_t          tok_o
);

  logic [HASH_W-1:0] coord_ext;
  logic [HASH_W-1:0] prod;
  logic              valid_r;
  logic [HASH_W-1:0] acc_r;
  logic [HASH_W-1:0] acc_nxt;

  // sign-extend, multiply, accumulate (wraps at HASH_W bits)
  assign coord_ext = HASH_W'(signed'(coord_i));
  assign prod      = coord_ext * HASH_W'(mul_i);
  assign acc_nxt   = tok_i.acc + prod;

  // token valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tok_i.valid;
    end
  end

  // partial sum
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign tok_o = '{valid: valid_r, acc: acc_r};

endmodule

### design/point_key_hash_multimap.sv
// ----------------------------------------------------------------------------
// point_key_hash_multimap
// Hash multimap keyed by a 3D integer point, chained buckets over a fixed
// entry store with a free list.
// ----------------------------------------------------------------------------
// Usage:
//   An operation is taken when start is high and busy is low (in_func:
//   insert, search or delete; in_key_x/y/z; in_new_value for inserts).
//   Exactly one result follows, shown for one cycle with out_valid high;
//   the receiver always takes it. out_entry_count is the store count after
//   the operation. The next start may be given in the strobe cycle.
// Path (accept to strobe): the row of hash cells, the registered bucket
//   head read, then one chain entry per cycle through the registered entry
//   RAMs. Insert, full insert, miss on an empty bucket and an unused code
//   answer right after the head read; a search walks to its match or to
//   the chain end; a delete hit adds the free-list step (one extra link
//   RAM write).
//   Busy stays high from accept to strobe, so one operation is in flight.
// Reset: synchronous, active low. After reset a clearing pass writes the
//   null link into every bucket head, with busy high throughout.
// ----------------------------------------------------------------------------
module point_key_hash_multimap import pkhm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_func,
  input  logic signed [COORD_W-1:0] in_key_x,
  input  logic signed [COORD_W-1:0] in_key_y,
  input  logic signed [COORD_W-1:0] in_key_z,
  input  logic signed [VALUE_W-1:0] in_new_value,
  output logic                      out_valid,
  output logic                      out_found,
  output logic signed [VALUE_W-1:0] out_result_value,
  output logic                      out_full_res,
  output logic [COUNT_W-1:0]        out_entry_count
);

  // FSM codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_FIRST = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_FREE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [BKT_W-1:0]   clr_r, clr_nxt;
  logic [PTR_W-1:0]   free_head_r, free_head_nxt;
  logic [PTR_W-1:0]   hw_r, hw_nxt;
  logic [PTR_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   cur_r, cur_nxt;
  logic [PTR_W-1:0]   prev_r, prev_nxt;
  logic [PTR_W-1:0]   steps_r, steps_nxt;
  logic [BKT_W-1:0]   bucket_r, bucket_nxt;
  logic               out_valid_r;
  logic               found_r;
  logic [VALUE_W-1:0] value_r;
  logic               full_r;

  // latched operation
  logic [1:0]         op_r;
  logic [COORD_W-1:0] key_r [NUM_AXES];
  logic [VALUE_W-1:0] new_value_r;
  logic [KEY_W-1:0]   key_pack;

  logic accept;
  logic respond;
  logic rsp_found;
  logic [VALUE_W-1:0] rsp_value;
  logic rsp_full;
  logic key_match;

  // RAM ports
  logic             head_we;
  logic [BKT_W-1:0] head_waddr;
  logic [PTR_W-1:0] head_wdata;
  logic [BKT_W-1:0] head_raddr;
  logic [PTR_W-1:0] head_rdata;
  logic             ent_we;
  logic [PTR_W-1:0] ent_waddr;
  logic [PTR_W-1:0] ent_raddr;
  logic [KEY_W-1:0] key_rdata;
  logic [VALUE_W-1:0] data_rdata;
  logic             link_we;
  logic [PTR_W-1:0] link_waddr;
  logic [PTR_W-1:0] link_wdata;
  logic [PTR_W-1:0] link_rdata;

  // hash cell row
  hash_tok_t          tok [NUM_AXES+1];
  logic [COORD_W-1:0] coord_in [NUM_AXES];

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign key_pack = {key_r[2], key_r[1], key_r[0]};
  assign key_match = (key_rdata == key_pack);

  // first cell takes x straight from the port, later cells use latched keys
  assign tok[0] = '{valid: accept, acc: '0};

  always_comb begin
    coord_in[0] = in_key_x;
    coord_in[1] = key_r[1];
    coord_in[2] = key_r[2];
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_cell
    pkhm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (tok[i]),
      .coord_i (coord_in[i]),
      .mul_i   (HASH_MUL[i]),
      .tok_o   (tok[i+1])
    );
  end

  assign head_raddr = tok[NUM_AXES].acc[BKT_W-1:0];

  // memories
  pkhm_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  pkhm_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr[IDX_W-1:0]),
    .wdata (key_pack),
    .raddr (ent_raddr[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  pkhm_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr[IDX_W-1:0]),
    .wdata (new_value_r),
    .raddr (ent_raddr[IDX_W-1:0]),
    .rdata (data_rdata)
  );

  pkhm_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr[IDX_W-1:0]),
    .wdata (link_wdata),
    .raddr (ent_raddr[IDX_W-1:0]),
    .rdata (link_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    free_head_nxt = free_head_r;
    hw_nxt        = hw_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    bucket_nxt    = bucket_r;
    respond       = 1'b0;
    rsp_found     = 1'b0;
    rsp_value     = '0;
    rsp_full      = 1'b0;
    head_we       = 1'b0;
    head_waddr    = bucket_r;
    head_wdata    = free_head_r;
    ent_we        = 1'b0;
    ent_waddr     = free_head_r;
    ent_raddr     = cur_r;
    link_we       = 1'b0;
    link_waddr    = free_head_r;
    link_wdata    = head_rdata;

    unique case (state_r)
      // null every bucket head after reset
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        head_wdata = NIL;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == BKT_W'(BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_HASH;
        end
      end

      // wait for the hash; read the head and the free entry's link
      ST_HASH: begin
        ent_raddr = free_head_r;
        if (tok[NUM_AXES].valid) begin
          bucket_nxt = tok[NUM_AXES].acc[BKT_W-1:0];
          state_nxt  = ST_FIRST;
        end
      end

      ST_FIRST: begin
        unique case (op_r)
          FN_INSERT: begin
            respond   = 1'b1;
            state_nxt = ST_IDLE;
            if (count_r == PTR_W'(CAPACITY)) begin
              rsp_full = 1'b1;
            end else begin
              // new entry goes to the chain head
              ent_we     = 1'b1;
              link_we    = 1'b1;
              head_we    = 1'b1;
              count_nxt  = count_r + 1'b1;
              if (free_head_r == hw_r) begin
                free_head_nxt = hw_r + 1'b1;
                hw_nxt        = hw_r + 1'b1;
              end else begin
                free_head_nxt = link_rdata;
              end
            end
          end
          FN_SEARCH, FN_DELETE: begin
            cur_nxt   = head_rdata;
            prev_nxt  = NIL;
            steps_nxt = '0;
            ent_raddr = head_rdata;
            if (head_rdata == NIL) begin
              respond   = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_WALK;
            end
          end
          default: begin
            respond   = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end

      // compare one chain entry per cycle
      ST_WALK: begin
        if (key_match) begin
          if (op_r == FN_SEARCH) begin
            respond   = 1'b1;
            rsp_found = 1'b1;
            rsp_value = data_rdata;
            state_nxt = ST_IDLE;
          end else begin
            // unlink from the head or from the previous entry
            if (prev_r == NIL) begin
              head_we    = 1'b1;
              head_wdata = link_rdata;
            end else begin
              link_we    = 1'b1;
              link_waddr = prev_r;
              link_wdata = link_rdata;
            end
            state_nxt = ST_FREE;
          end
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = link_rdata;
          steps_nxt = steps_r + 1'b1;
          ent_raddr = link_rdata;
          if (link_rdata == NIL || steps_nxt == PTR_W'(CAPACITY)) begin
            respond   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end

      // push the removed entry onto the free list
      ST_FREE: begin
        link_we       = 1'b1;
        link_waddr    = cur_r;
        link_wdata    = free_head_r;
        free_head_nxt = cur_r;
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        respond   = 1'b1;
        rsp_found = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      free_head_r <= '0;
      hw_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      hw_r        <= hw_nxt;
      count_r     <= count_nxt;
      out_valid_r <= respond;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    steps_r  <= steps_nxt;
    bucket_r <= bucket_nxt;
    if (accept) begin
      op_r        <= in_func;
      key_r[0]    <= in_key_x;
      key_r[1]    <= in_key_y;
      key_r[2]    <= in_key_z;
      new_value_r <= in_new_value;
    end
    if (respond) begin
      found_r <= rsp_found;
      value_r <= rsp_value;
      full_r  <= rsp_full;
    end
  end

  // result ports
  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_result_value = value_r;
  assign out_full_res     = full_r;
  assign out_entry_count  = COUNT_W'(count_r);

endmodule

### tb/point_key_hash_multimap_test.sv
// ----------------------------------------------------------------------------
// point_key_hash_multimap_test
// Self-checking bench for the point key hash multimap. A directed table of
// operations runs first, then constrained-by-hand random traffic that mixes
// hits, misses, bucket collisions and shadowed duplicates, fills the entry
// store until inserts are dropped, and thins it out again. Every result is
// compared field by field against an in-bench model of the chained table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_key_hash_multimap_test;
  import pkhm_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int POOL_N         = 48;

  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic [31:0] MUL_X = 32'd18397;
  localparam logic [31:0] MUL_Y = 32'd20483;
  localparam logic [31:0] MUL_Z = 32'd29303;

  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] ONES = 32'hffff_ffff;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] value;
    logic               full;
    logic [COUNT_W-1:0] count;
  } map_result_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [VALUE_W-1:0] value;
    logic               typed;
    map_result_t        want;
  } drill_row_t;

  // Directed operations; typed rows carry their own answer, the rest use the model
  localparam drill_row_t DRILL [25] = '{
    '{FN_SEARCH, MAXV, MAXV, MAXV, 32'd0, 1'b1, '{1'b0, 32'd0, 1'b0, 11'd0}},
    '{FN_DELETE, MINV, MINV, MINV, 32'd0, 1'b1, '{1'b0, 32'd0, 1'b0, 11'd0}},
    '{FN_UNUSED, MAXV, MAXV, MAXV, MAXV,  1'b1, '{1'b0, 32'd0, 1'b0, 11'd0}},
    '{FN_INSERT, MAXV, MAXV, MAXV, MAXV,  1'b1, '{1'b0, 32'd0, 1'b0, 11'd1}},
    '{FN_SEARCH, MAXV, MAXV, MAXV, 32'd0, 1'b1, '{1'b1, MAXV,  1'b0, 11'd1}},
    '{FN_INSERT, MINV, MINV, MINV, MINV,  1'b1, '{1'b0, 32'd0, 1'b0, 11'd2}},
    '{FN_SEARCH, MINV, MINV, MINV, 32'd0, 1'b1, '{1'b1, MINV,  1'b0, 11'd2}},
    '{FN_INSERT, MAXV, MAXV, MAXV, ONES,  1'b1, '{1'b0, 32'd0, 1'b0, 11'd3}},
    '{FN_SEARCH, MAXV, MAXV, MAXV, 32'd0, 1'b1, '{1'b1, ONES,  1'b0, 11'd3}},
    '{FN_DELETE, MAXV, MAXV, MAXV, 32'd0, 1'b1, '{1'b1, 32'd0, 1'b0, 11'd2}},
    '{FN_SEARCH, MAXV, MAXV, MAXV, 32'd0, 1'b1, '{1'b1, MAXV,  1'b0, 11'd2}},
    '{FN_DELETE, MAXV, MAXV, MAXV, 32'd0, 1'b1, '{1'b1, 32'd0, 1'b0, 11'd1}},
    '{FN_SEARCH, MAXV, MAXV, MAXV, 32'd0, 1'b1, '{1'b0, 32'd0, 1'b0, 11'd1}},
    '{FN_DELETE, MAXV, MAXV, MAXV, 32'd0, 1'b1, '{1'b0, 32'd0, 1'b0, 11'd1}},
    '{FN_INSERT, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{1'b0, 32'd0, 1'b0, 11'd2}},
    '{FN_SEARCH, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{1'b1, 32'd0, 1'b0, 11'd2}},
    // keys that share the bucket of the origin, chained ahead of it
    '{FN_INSERT, 32'd1024, 32'd0, 32'd0, 32'h11, 1'b0, '0},
    '{FN_INSERT, 32'd2048, 32'd0, 32'd0, 32'h22, 1'b0, '0},
    '{FN_INSERT, 32'd0, 32'd1024, 32'hffff_fc00, 32'h33, 1'b0, '0},
    '{FN_SEARCH, 32'd1024, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{FN_DELETE, 32'd1024, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{FN_SEARCH, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{FN_DELETE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{FN_SEARCH, 32'd2048, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{FN_UNUSED, 32'd0, 32'd1024, 32'hffff_fc00, ONES, 1'b0, '0}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_func;
  logic signed [COORD_W-1:0] in_key_x;
  logic signed [COORD_W-1:0] in_key_y;
  logic signed [COORD_W-1:0] in_key_z;
  logic signed [VALUE_W-1:0] in_new_value;
  logic                      out_valid;
  logic                      out_found;
  logic signed [VALUE_W-1:0] out_result_value;
  logic                      out_full_res;
  logic [COUNT_W-1:0]        out_entry_count;

  point_key_hash_multimap dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_key_x         (in_key_x),
    .in_key_y         (in_key_y),
    .in_key_z         (in_key_z),
    .in_new_value     (in_new_value),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_result_value (out_result_value),
    .out_full_res     (out_full_res),
    .out_entry_count  (out_entry_count)
  );

  // Model of the table: chain heads, entry store, free list, count
  logic [PTR_W-1:0]   chain_head [BUCKETS];
  logic [KEY_W-1:0]   slot_key   [CAPACITY];
  logic [VALUE_W-1:0] slot_data  [CAPACITY];
  logic [PTR_W-1:0]   slot_next  [CAPACITY];
  logic [PTR_W-1:0]   free_head;
  int                 stored;

  map_result_t        pending_results [$];
  logic [KEY_W-1:0]   key_pool [POOL_N];
  int                 errors;
  int                 idle_cycles;
  int                 calm_left;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic logic [31:0] widen(logic [COORD_W-1:0] c);
    return 32'(signed'(c));
  endfunction

  function automatic int bucket_index(logic [KEY_W-1:0] k);
    logic [31:0] h;
    h = widen(k[3*COORD_W-1 -: COORD_W]) * MUL_X
      + widen(k[2*COORD_W-1 -: COORD_W]) * MUL_Y
      + widen(k[COORD_W-1:0]) * MUL_Z;
    return int'(h % BUCKETS);
  endfunction

  // Applies one operation to the model and returns the result it must produce
  function automatic map_result_t apply_map_op(logic [1:0] fn, logic [KEY_W-1:0] k,
                                               logic [VALUE_W-1:0] val);
    map_result_t r;
    int b;
    int e;
    int prev;
    int steps;
    r = '0;
    b = bucket_index(k);
    case (fn)
      FN_INSERT: begin
        if (stored >= CAPACITY || free_head == NIL) begin
          r.full = 1'b1;
        end else begin
          e = int'(free_head);
          free_head = slot_next[e];
          slot_key[e] = k;
          slot_data[e] = val;
          slot_next[e] = chain_head[b];
          chain_head[b] = PTR_W'(e);
          stored++;
        end
      end
      FN_SEARCH: begin
        e = int'(chain_head[b]);
        for (steps = 0; e < CAPACITY && steps < CAPACITY; steps++) begin
          if (slot_key[e] == k) begin
            r.found = 1'b1;
            r.value = slot_data[e];
            break;
          end
          e = int'(slot_next[e]);
        end
      end
      FN_DELETE: begin
        prev = CAPACITY;
        e = int'(chain_head[b]);
        for (steps = 0; e < CAPACITY && steps < CAPACITY; steps++) begin
          if (slot_key[e] == k) begin
            // unlink the newest match and push it on the free list
            if (prev == CAPACITY) chain_head[b] = slot_next[e];
            else slot_next[prev] = slot_next[e];
            slot_next[e] = free_head;
            free_head = PTR_W'(e);
            if (stored > 0) stored--;
            r.found = 1'b1;
            break;
          end
          prev = e;
          e = int'(slot_next[e]);
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(stored);
    return r;
  endfunction

  // Sender gaps: mostly none or short, a few long, with calm stretches of none
  function automatic int pick_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return COORD_W'(MAXV);
          1: return COORD_W'(MINV);
          2: return '0;
          default: return '1;
        endcase
      end
      1: return COORD_W'($urandom_range(0, 15) - 8);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return key_pool[$urandom_range(0, POOL_N - 1)];
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // One command transfer; the expectation is queued at the accepting edge
  task automatic send_op(int gap, logic [1:0] fn, logic [KEY_W-1:0] k,
                         logic [VALUE_W-1:0] val, logic typed, map_result_t typed_res);
    map_result_t predicted;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    in_func      <= fn;
    in_key_x     <= k[3*COORD_W-1 -: COORD_W];
    in_key_y     <= k[2*COORD_W-1 -: COORD_W];
    in_key_z     <= k[COORD_W-1:0];
    in_new_value <= val;
    do @(posedge clk); while (busy);
    predicted = apply_map_op(fn, k, val);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic random_op(int ins_pct, int del_pct, int pool_pct);
    int roll;
    logic [1:0] fn;
    roll = $urandom_range(0, 99);
    if (roll < 2) fn = FN_UNUSED;
    else if (roll < 2 + ins_pct) fn = FN_INSERT;
    else if (roll < 2 + ins_pct + del_pct) fn = FN_DELETE;
    else fn = FN_SEARCH;
    send_op(pick_gap(), fn, pick_key(pool_pct), VALUE_W'($urandom), 1'b0, '0);
  endtask

  // Result checking against the oldest expectation
  always @(posedge clk) begin : result_check
    map_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: found %0b value %0h full %0b count %0d",
                 $time, out_found, out_result_value, out_full_res, out_entry_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", 32'(want.found), 32'(out_found));
        check_field("result_value", want.value, out_result_value);
        check_field("full_res", 32'(want.full), 32'(out_full_res));
        check_field("entry_count", 32'(want.count), 32'(out_entry_count));
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("point_key_hash_multimap test failed");
      $finish;
    end
  end

  initial begin
    int i;
    int g;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_func      = FN_INSERT;
    in_key_x     = '0;
    in_key_y     = '0;
    in_key_z     = '0;
    in_new_value = '0;
    errors       = 0;
    idle_cycles  = 0;
    calm_left    = 0;

    // model after reset: empty chains, every entry on the free list
    for (i = 0; i < BUCKETS; i++) chain_head[i] = NIL;
    for (i = 0; i < CAPACITY; i++) begin
      slot_key[i]  = '0;
      slot_data[i] = '0;
      slot_next[i] = PTR_W'(i + 1);
    end
    free_head = '0;
    stored    = 0;

    // groups of four keys; the last three share the first's bucket unless y carries
    for (i = 0; i < POOL_N; i++) begin
      g = i - (i % 4);
      case (i % 4)
        0: key_pool[i] = {rand_coord(), rand_coord(), rand_coord()};
        1: key_pool[i] = key_pool[g]
                         + {COORD_W'(1024 * $urandom_range(1, 15)), {2*COORD_W{1'b0}}};
        2: key_pool[i] = key_pool[g]
                         + {{COORD_W{1'b0}}, COORD_W'(1024 * $urandom_range(1, 15)),
                            {COORD_W{1'b0}}};
        default: key_pool[i] = {key_pool[g][KEY_W-1:COORD_W],
                                key_pool[g][COORD_W-1:0]
                                - COORD_W'(1024 * $urandom_range(1, 15))};
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (DRILL[i])
      send_op(pick_gap(), DRILL[i].func, {DRILL[i].x, DRILL[i].y, DRILL[i].z},
              DRILL[i].value, DRILL[i].typed, DRILL[i].want);

    // mixed traffic on a small key set: hits, duplicates, collisions
    repeat (150) random_op(40, 25, 75);

    // fill the store, then work around the full point
    while (stored < CAPACITY) random_op(92, 3, 30);
    repeat (100) random_op(50, 20, 50);

    // hold the sender until every outstanding result is back
    @(negedge clk);
    start <= 1'b0;
    wait (pending_results.size() == 0);

    // thin the store with delete-heavy traffic
    repeat (150) random_op(15, 60, 70);

    @(negedge clk);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("point_key_hash_multimap test passed");
    end else begin
      $display("point_key_hash_multimap test failed");
    end
    $finish;
  end

endmodule

### files.f
design/pkhm_pkg.sv
design/pkhm_ram.sv
design/pkhm_cell.sv
design/point_key_hash_multimap.sv
tb/point_key_hash_multimap_test.sv
